FILE: rtl/dppt_pkg.sv
package dppt_pkg;

	// field widths
	localparam int PAD_W    = 4;
	localparam int RAW_W    = 12;
	localparam int LEVEL_W  = 8;
	localparam int KEY_W    = 7;
	localparam int STATUS_W = 8;
	localparam int CHAN_W   = 4;
	localparam int MAP_W    = 35;
	localparam int CFG_W    = MAP_W;
	localparam int PADS_PER_MAP = 5;

	localparam logic [STATUS_W-1:0] NOTE_ON_STATUS = 8'h90;

	// per-pad state word held in the RAM
	typedef struct packed {
		logic [LEVEL_W-1:0] holdoff;
		logic [LEVEL_W-1:0] prev_level;
	} pad_entry_t;

	localparam int ENTRY_W = $bits(pad_entry_t);

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_HOLDOFF   = 3'd1,
		REG_CHANNEL   = 3'd2,
		REG_MAP_LOW   = 3'd3,
		REG_MAP_HIGH  = 3'd4
	} reg_idx_t;

endpackage

FILE: rtl/dppt_if.sv
interface dppt_sample_if
	import dppt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PAD_W-1:0] pad_index;
	logic [RAW_W-1:0] raw_sample;

	modport source (output valid, pad_index, raw_sample, input ready);
	modport sink   (input valid, pad_index, raw_sample, output ready);
endinterface

interface dppt_note_if
	import dppt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status_byte;
	logic [KEY_W-1:0]    key_byte;
	logic [KEY_W-1:0]    velocity_byte;

	modport source (output valid, status_byte, key_byte, velocity_byte, input ready);
	modport sink   (input valid, status_byte, key_byte, velocity_byte, output ready);
endinterface

FILE: rtl/drum_pad_peak_trigger.sv
// The sample transfer edge reads the pad state RAM into stage 1, and the result
// register loads when stage 1 moves on; a note-on is valid from that load.
// Throughput: one sample per cycle through a single read-modify-write of the pad
// state RAM, with a write-back to the pad being read forwarded. Any sample waits
// in stage 1 while an undrained note-on holds the result register.
// Reset: control registers go to defaults; per-pad flags make every pad read cleared.
module drum_pad_peak_trigger
	import dppt_pkg::*;
#(
	parameter int NUM_PADS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [CFG_W-1:0]   wr_data,
	dppt_sample_if.sink        sample,
	dppt_note_if.source        note
);

	localparam int AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [LEVEL_W-1:0] threshold_q;
	logic [LEVEL_W-1:0] holdoff_q;
	logic [CHAN_W-1:0]  channel_q;
	logic [MAP_W-1:0]   map_low_q;
	logic [MAP_W-1:0]   map_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 8'd20;
			holdoff_q   <= 8'd50;
			channel_q   <= 4'd10;
			map_low_q   <= 35'd12178954534;
			map_high_q  <= 35'd15408583851;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_THRESHOLD: threshold_q <= wr_data[LEVEL_W-1:0];
				REG_HOLDOFF:   holdoff_q   <= wr_data[LEVEL_W-1:0];
				REG_CHANNEL:   channel_q   <= wr_data[CHAN_W-1:0];
				REG_MAP_LOW:   map_low_q   <= wr_data[MAP_W-1:0];
				REG_MAP_HIGH:  map_high_q  <= wr_data[MAP_W-1:0];
				default: ; // unused indexes are ignored
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake and stage 1 control
	// ---------------------------------------------------------------
	logic s1_valid_q;
	logic s1_go;
	logic in_xfer;
	logic out_valid_q;

	// stage 1 moves on when the result register is free or being drained
	assign s1_go        = s1_valid_q && (!out_valid_q || note.ready);
	assign sample.ready = !s1_valid_q || s1_go;
	assign in_xfer      = sample.valid && sample.ready;

	logic             in_range;
	assign in_range = {1'b0, sample.pad_index} < (PAD_W+1)'(NUM_PADS);

	// stage 1 payload
	logic [PAD_W-1:0]   pad_s1;
	logic               in_range_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic               fwd_s1;
	pad_entry_t         fwd_data_s1;

	// ---------------------------------------------------------------
	// Pad state RAM: holdoff counter and previous level per pad
	// ---------------------------------------------------------------
	logic [ENTRY_W-1:0] ram_rdata;
	logic               ram_we;
	pad_entry_t         new_entry;
	logic [NUM_PADS-1:0] written_q;

	assign ram_we = s1_go && in_range_s1;

	dppt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_PADS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pad_s1[AW-1:0]),
		.wdata (new_entry),
		.re    (in_xfer && in_range),
		.raddr (sample.pad_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Same pad written back on the edge it is read again: the RAM would return
	// stale data, so the write-back word is captured and used instead.
	logic fwd_hit;
	assign fwd_hit = ram_we && (sample.pad_index == pad_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
			written_q  <= '0;
		end else begin
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
				fwd_s1     <= fwd_hit;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
				fwd_s1     <= 1'b0;
			end
			if (ram_we) begin
				written_q[pad_s1[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pad_s1      <= sample.pad_index;
			in_range_s1 <= in_range;
			level_s1    <= sample.raw_sample[LEVEL_W:1];
			fwd_data_s1 <= new_entry;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: peak test and state update
	// ---------------------------------------------------------------
	pad_entry_t cur_entry;
	logic       busy;
	logic       trig;

	always_comb begin
		if (fwd_s1) begin
			cur_entry = fwd_data_s1;
		end else if (written_q[pad_s1[AW-1:0]]) begin
			cur_entry = pad_entry_t'(ram_rdata);
		end else begin
			cur_entry = '0; // never written since reset
		end
	end

	assign busy = cur_entry.holdoff != '0;
	// falling peak above threshold
	assign trig = !busy && (level_s1 > threshold_q) && (level_s1 < cur_entry.prev_level);

	always_comb begin
		if (busy) begin
			new_entry.holdoff    = cur_entry.holdoff - 8'd1;
			new_entry.prev_level = cur_entry.prev_level;
		end else if (trig) begin
			new_entry.holdoff    = holdoff_q;
			new_entry.prev_level = '0;
		end else begin
			new_entry.holdoff    = '0;
			new_entry.prev_level = level_s1;
		end
	end

	// key lookup: pads 0-4 in the low map, the rest in the high map
	logic [MAP_W-1:0] key_map;
	logic [PAD_W-1:0] slot;
	logic [KEY_W-1:0] key;

	always_comb begin
		if (pad_s1 < PAD_W'(PADS_PER_MAP)) begin
			key_map = map_low_q;
			slot    = pad_s1;
		end else begin
			key_map = map_high_q;
			slot    = pad_s1 - PAD_W'(PADS_PER_MAP);
		end
		case (slot)
			4'd0:    key = key_map[0*KEY_W +: KEY_W];
			4'd1:    key = key_map[1*KEY_W +: KEY_W];
			4'd2:    key = key_map[2*KEY_W +: KEY_W];
			4'd3:    key = key_map[3*KEY_W +: KEY_W];
			4'd4:    key = key_map[4*KEY_W +: KEY_W];
			default: key = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic               emit;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   velocity_q;

	assign emit = s1_go && in_range_s1 && trig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (note.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= NOTE_ON_STATUS | {4'd0, channel_q};
			key_q      <= key;
			velocity_q <= level_s1[KEY_W-1:0];
		end
	end

	assign note.valid         = out_valid_q;
	assign note.status_byte   = status_q;
	assign note.key_byte      = key_q;
	assign note.velocity_byte = velocity_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_valid_q)
		else $error("forwarded state without an item in stage 1");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, pad_s1} < (PAD_W+1)'(NUM_PADS)))
		else $error("state write to a pad out of range");

	a_trigger_loads_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (new_entry.holdoff == holdoff_q && new_entry.prev_level == '0))
		else $error("trigger did not reload the hold-off");

	a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && busy) |-> !emit)
		else $error("note-on issued during hold-off");

endmodule

FILE: rtl/dppt_ram.sv
module dppt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: test/tb_top.sv
module tb_top
	import dppt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PADS = 10;

	// run control
	localparam int CYCLE_LIMIT  = 200000; // watchdog, far above any sane run
	localparam int LONG_HOLD    = 300;    // note sink held off this long under pressure
	localparam int SETTLE_TAIL  = 4;      // margin for the pipe to empty after the last note-on
	localparam int FINAL_WAIT   = 2000;   // bound on the final drain

	// register defaults after reset
	localparam logic [LEVEL_W-1:0] THR_RESET  = 8'd20;
	localparam logic [LEVEL_W-1:0] HOLD_RESET = 8'd50;
	localparam logic [CHAN_W-1:0]  CHAN_RESET = 4'd10;
	localparam logic [MAP_W-1:0]   MAP_LOW_RESET  = 35'd12178954534;
	localparam logic [MAP_W-1:0]   MAP_HIGH_RESET = 35'd15408583851;

	// first index past the register file; writes here must be ignored
	localparam int REG_COUNT = 5;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key;
		logic [KEY_W-1:0]    velocity;
	} note_t;

	// Shadow of the pad trigger: register copies, per-pad hold-off and
	// previous level, and the queue of note-ons still owed by the block.
	class note_scoreboard;
		logic [LEVEL_W-1:0] threshold;
		logic [LEVEL_W-1:0] holdoff_load;
		logic [CHAN_W-1:0]  channel;
		logic [MAP_W-1:0]   map_low;
		logic [MAP_W-1:0]   map_high;
		logic [LEVEL_W-1:0] holdoff_left [NUM_PADS];
		logic [LEVEL_W-1:0] prev_level [NUM_PADS];
		note_t              owed_notes [$];
		int                 samples;
		int                 ignored;
		int                 notes_ok;
		int                 errors;

		function new();
			threshold    = THR_RESET;
			holdoff_load = HOLD_RESET;
			channel      = CHAN_RESET;
			map_low      = MAP_LOW_RESET;
			map_high     = MAP_HIGH_RESET;
			foreach (holdoff_left[i]) begin
				holdoff_left[i] = '0;
				prev_level[i]   = '0;
			end
			samples  = 0;
			ignored  = 0;
			notes_ok = 0;
			errors   = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_THRESHOLD: threshold    = data[LEVEL_W-1:0];
				REG_HOLDOFF:   holdoff_load = data[LEVEL_W-1:0];
				REG_CHANNEL:   channel      = data[CHAN_W-1:0];
				REG_MAP_LOW:   map_low      = data[MAP_W-1:0];
				REG_MAP_HIGH:  map_high     = data[MAP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [KEY_W-1:0] key_of(int pad);
			logic [MAP_W-1:0] map;
			int slot;
			map  = map_low;
			slot = pad;
			if (slot >= PADS_PER_MAP) begin
				map  = map_high;
				slot = slot - PADS_PER_MAP;
			end
			return KEY_W'(map >> (KEY_W * slot));
		endfunction

		// one sample transfer: update the pad and queue a note-on if it fires
		function void note_sample(logic [PAD_W-1:0] pad, logic [RAW_W-1:0] raw);
			logic [LEVEL_W-1:0] lvl;
			note_t n;
			samples++;
			if (pad >= NUM_PADS) begin
				ignored++;
				return;
			end
			lvl = raw[LEVEL_W:1];
			if (holdoff_left[pad] != 0) begin
				holdoff_left[pad]--;
				return;
			end
			if (lvl > threshold && lvl < prev_level[pad]) begin
				n.status   = NOTE_ON_STATUS | STATUS_W'(channel);
				n.key      = key_of(int'(pad));
				n.velocity = lvl[KEY_W-1:0];
				owed_notes.push_back(n);
				holdoff_left[pad] = holdoff_load;
				prev_level[pad]   = '0;
			end else begin
				prev_level[pad] = lvl;
			end
		endfunction

		// one note transfer: compare against the oldest owed note-on
		function void check_note(note_t got);
			note_t exp_n;
			if (owed_notes.size() == 0) begin
				$display("%0t: unexpected note-on status %h key %h velocity %h",
					$time, got.status, got.key, got.velocity);
				errors++;
				return;
			end
			exp_n = owed_notes.pop_front();
			if (got.status !== exp_n.status) begin
				$display("%0t: status_byte expected %h actual %h",
					$time, exp_n.status, got.status);
				errors++;
			end
			if (got.key !== exp_n.key) begin
				$display("%0t: key_byte expected %h actual %h", $time, exp_n.key, got.key);
				errors++;
			end
			if (got.velocity !== exp_n.velocity) begin
				$display("%0t: velocity_byte expected %h actual %h",
					$time, exp_n.velocity, got.velocity);
				errors++;
			end
			if (got === exp_n)
				notes_ok++;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              wr_en;
	logic [2:0]        wr_index;
	logic [CFG_W-1:0]  wr_data;

	dppt_sample_if sample_ch ();
	dppt_note_if   note_ch ();

	note_scoreboard sb;

	// idling knobs, percent of cycles; set per phase from the main sequence
	int send_idle_pct;
	int recv_stall_pct;

	// long note hold-off: main bumps the order count, the sink counts it out
	int hold_orders;

	int phases_run;

	drum_pad_peak_trigger #(
		.NUM_PADS (NUM_PADS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sample   (sample_ch.sink),
		.note     (note_ch.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a note-on that never shows up ends here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: run timed out", $time);
		$display("FAIL");
		$finish;
	end

	// Monitor: both channels are sampled at the edge, before any of this
	// edge's nonblocking updates land. The sample goes to the shadow first so
	// a note-on in the same cycle still pops the oldest owed entry.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.pad_index, sample_ch.raw_sample);
			if (note_ch.valid && note_ch.ready)
				sb.check_note({note_ch.status_byte, note_ch.key_byte, note_ch.velocity_byte});
		end
	end

	// Note sink: random stalls per the phase, or a long solid hold-off when
	// ordered, counted here so the sender keeps pushing meanwhile.
	initial begin : note_sink
		int hold_left;
		int hold_taken;
		hold_left  = 0;
		hold_taken = 0;
		note_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_orders != hold_taken) begin
				hold_taken = hold_orders;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				note_ch.ready <= 1'b0;
			end else begin
				note_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// One sample transfer. Valid only drops when the sender actually idles,
	// so back-to-back transfers never see a low-then-high in one step.
	task automatic send_sample(input logic [PAD_W-1:0] pad, input logic [RAW_W-1:0] raw);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.pad_index  <= pad;
		sample_ch.raw_sample <= raw;
		do
			@(posedge clk);
		while (!sample_ch.ready);
	endtask

	// raw word carrying a given level, with the discarded bits randomised
	function automatic logic [RAW_W-1:0] raw_of(input int lvl);
		logic [RAW_W-LEVEL_W-2:0] top;
		logic                     lsb;
		top = (RAW_W-LEVEL_W-1)'($urandom);
		lsb = 1'($urandom);
		return {top, LEVEL_W'(lvl), lsb};
	endfunction

	function automatic logic [MAP_W-1:0] rand_map();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAP_W-1:0];
	endfunction

	// Stop offering, let the owed note-ons come back, then allow the pipe to
	// empty of samples that fire nothing. The first edge makes sure the last
	// transfer has reached the shadow.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] hold,
			input logic [CHAN_W-1:0] chan, input logic [MAP_W-1:0] lo,
			input logic [MAP_W-1:0] hi);
		settle();
		write_reg(REG_THRESHOLD, CFG_W'(thr));
		write_reg(REG_HOLDOFF, CFG_W'(hold));
		write_reg(REG_CHANNEL, CFG_W'(chan));
		write_reg(REG_MAP_LOW, lo);
		write_reg(REG_MAP_HIGH, hi);
		wr_en <= 1'b0;
	endtask

	// A struck pad: a rising run to a peak, one lower sample above threshold
	// that fires, then roughly the hold-off's worth of samples on that pad so
	// it comes live again (one short or one over now and then).
	task automatic send_hit(output int sent);
		logic [PAD_W-1:0] pad;
		int thr, peak, fall, rises, fill;
		pad  = PAD_W'($urandom_range(NUM_PADS - 1));
		thr  = int'(sb.threshold);
		sent = 0;
		if (thr >= 253) begin
			// threshold near the top: no hit is built; just exercise the pad
			repeat (2) send_sample(pad, RAW_W'($urandom));
			sent = 2;
			return;
		end
		peak  = $urandom_range(255, thr + 2);
		fall  = $urandom_range(peak - 1, thr + 1);
		rises = $urandom_range(2);
		for (int i = 0; i < rises; i++)
			send_sample(pad, raw_of((peak * (i + 1)) / (rises + 2)));
		send_sample(pad, raw_of(peak));
		send_sample(pad, raw_of(fall));
		sent = rises + 2;
		fill = int'(sb.holdoff_load) + $urandom_range(2) - 1;
		for (int i = 0; i < fill; i++)
			send_sample(pad, RAW_W'($urandom));
		if (fill > 0)
			sent += fill;
	endtask

	// junk: any pad number, dead pads included, any raw value
	task automatic send_noise(output int sent);
		logic [PAD_W-1:0] pad;
		int n;
		sent = 0;
		n    = $urandom_range(3, 1);
		for (int i = 0; i < n; i++) begin
			pad = PAD_W'($urandom_range(15));
			send_sample(pad, RAW_W'($urandom));
			if (pad < NUM_PADS)
				sent++;
		end
	endtask

	task automatic run_phase(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] hold,
			input logic [CHAN_W-1:0] chan, input logic [MAP_W-1:0] lo,
			input logic [MAP_W-1:0] hi, input int send_pct, input int recv_pct,
			input int target, input bit long_hold, input bit mid_pause);
		int done, sent;
		bit paused;
		done   = 0;
		paused = 1'b0;
		configure(thr, hold, chan, lo, hi);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		phases_run++;
		if (long_hold)
			hold_orders <= hold_orders + 1;
		while (done < target) begin
			if (mid_pause && !paused && done >= target / 2) begin
				// sender waits for every owed note-on before going on
				settle();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 80)
				send_hit(sent);
			else
				send_noise(sent);
			done += sent;
		end
	endtask

	// Short hand-picked run: dead pads, level extremes, equal-to-threshold and
	// equal-to-previous levels, wrap of a high level to velocity zero, both
	// key maps, zero hold-off and then a short hold-off.
	task automatic run_directed();
		settle();
		// writes past the register file change nothing
		for (int j = REG_COUNT; j < (1 << $bits(wr_index)); j++)
			write_reg(j[2:0], '1);
		write_reg(REG_HOLDOFF, '0);
		wr_en <= 1'b0;
		phases_run++;
		send_sample(4'd10, 12'hFFF);  // first dead pad
		send_sample(4'd15, 12'hFFF);  // top dead pad
		send_sample(4'd0, 12'hFFF);   // level 255 stored
		send_sample(4'd0, 12'h100);   // level 128 fires, velocity wraps to 0
		send_sample(4'd0, 12'h064);   // live at once: zero hold-off
		send_sample(4'd0, 12'h03C);   // level 30 fires
		send_sample(4'd0, 12'h029);   // level 20 = threshold, stored
		send_sample(4'd0, 12'h028);   // still not above threshold
		send_sample(4'd0, 12'h000);   // level 0
		send_sample(4'd9, 12'h1FE);   // level 255 on the last pad
		send_sample(4'd9, 12'hFFD);   // 254 fires, top map
		send_sample(4'd5, 12'hE01);   // level 0 with discarded bits set
		send_sample(4'd5, 12'h0FF);   // level 127
		send_sample(4'd5, 12'h0FE);   // equal to previous, no fire
		send_sample(4'd5, 12'h0FC);   // 126 fires, first pad of top map
		send_sample(4'd4, 12'h0C8);   // last pad of low map
		send_sample(4'd4, 12'h02C);   // level 22 fires
		settle();
		write_reg(REG_HOLDOFF, CFG_W'(2));
		wr_en <= 1'b0;
		send_sample(4'd4, 12'hFFF);   // level 255 stored (pad live, count 0)
		send_sample(4'd4, 12'h0C8);   // fires, loads hold-off 2
		send_sample(4'd4, 12'hFFF);   // swallowed
		send_sample(4'd4, 12'h0C8);   // swallowed, counter reaches 0
		send_sample(4'd4, 12'hFFF);   // live again, stored
		send_sample(4'd4, 12'h0C8);   // fires
	endtask

	initial begin
		sb             = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_orders    = 0;
		phases_run     = 0;

		arst_n               <= 1'b0;
		wr_en                <= 1'b0;
		wr_index             <= '0;
		wr_data              <= '0;
		sample_ch.valid      <= 1'b0;
		sample_ch.pad_index  <= '0;
		sample_ch.raw_sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// extremes: fire on any fall above zero, no hold-off, all-zero / all-one maps
		run_phase('0, '0, '0, '0, '1, 0, 0, 300, 1'b0, 1'b0);
		// threshold at the top: nothing may fire; hold-off of one
		run_phase('1, 8'd1, '1, '1, '0, 66, 0, 150, 1'b0, 1'b0);
		// random settings, sink stalling, sender pauses halfway until drained
		run_phase(LEVEL_W'($urandom_range(150)), LEVEL_W'($urandom_range(7)),
			CHAN_W'($urandom), rand_map(), rand_map(), 0, 66, 350, 1'b0, 1'b1);
		run_phase(LEVEL_W'($urandom_range(150)), LEVEL_W'($urandom_range(7)),
			CHAN_W'($urandom), rand_map(), rand_map(), 38, 38, 350, 1'b0, 1'b0);
		// longest hold-off: only a few strikes fit
		run_phase(LEVEL_W'($urandom_range(60)), '1, CHAN_W'($urandom), rand_map(), rand_map(),
			38, 38, 600, 1'b0, 1'b0);
		// pressure: lots of note-ons while the sink holds off, input must stall
		run_phase('0, '0, CHAN_W'($urandom), rand_map(), rand_map(), 0, 0, 300, 1'b1, 1'b0);
		// back to the reset values
		run_phase(THR_RESET, HOLD_RESET, CHAN_RESET, MAP_LOW_RESET, MAP_HIGH_RESET,
			66, 0, 200, 1'b0, 1'b0);

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < FINAL_WAIT && sb.owed_notes.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
		if (sb.owed_notes.size() != 0) begin
			$display("%0t: %0d note-ons never arrived", $time, sb.owed_notes.size());
			sb.errors += sb.owed_notes.size();
		end

		$display("Sent %0d samples (%0d on dead pads) over %0d register settings,",
			sb.samples, sb.ignored, phases_run);
		$display("checked %0d note-ons, %0d mismatches.", sb.notes_ok, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
